// ===== sv/idct8_pkg.sv =====
// ============================================================================
// idct8_pkg
// Types and constants shared by the stages of the eight-point AAN row IDCT.
// ============================================================================
package idct8_pkg;

  // One 16-bit signed sample.
  typedef logic signed [15:0] smp_t;

  // Q8 multiplier constants of the butterfly network.
  localparam logic signed [11:0] K_SQRT2 = 12'sd362;
  localparam logic signed [11:0] K_C184  = 12'sd473;
  localparam logic signed [11:0] K_C261N = -12'sd669;
  localparam logic signed [11:0] K_C108  = 12'sd277;

  // Pixel clamp limits and level shift.
  localparam smp_t PIX_LOW   = -16'sd4096;
  localparam smp_t PIX_HIGH  = 16'sd4064;
  localparam smp_t PIX_SHIFT = 16'sd128;
  localparam smp_t PIX_MIN   = 16'sd0;
  localparam smp_t PIX_MAX   = 16'sd255;

  // Input request.
  typedef struct packed {
    smp_t coef_0;
    smp_t coef_1;
    smp_t coef_2;
    smp_t coef_3;
    smp_t coef_4;
    smp_t coef_5;
    smp_t coef_6;
    smp_t coef_7;
    logic raw_mode;
  } in_req_t;

  // Output request.
  typedef struct packed {
    smp_t out_0;
    smp_t out_1;
    smp_t out_2;
    smp_t out_3;
    smp_t out_4;
    smp_t out_5;
    smp_t out_6;
    smp_t out_7;
  } out_req_t;

  // Per-stage pipeline control.
  typedef struct packed {
    logic vld;   // an item is offered to the stage
    logic adv;   // the stage register may load
  } stg_ctl_t;

  // Stage 1: first butterflies and multiplier operands.
  typedef struct packed {
    logic                raw;
    smp_t                e10;
    smp_t                e11;
    smp_t                e13;
    logic signed [16:0]  d26;
    smp_t                z10;
    smp_t                z12;
    logic signed [16:0]  z11m13;
    logic signed [16:0]  z10p12;
    smp_t                x7;
  } s1_t;

  // Stage 2: scaled products, bits 23:8 of each.
  typedef struct packed {
    logic raw;
    smp_t e10;
    smp_t e11;
    smp_t e13;
    smp_t x7;
    smp_t m_e12;
    smp_t m_o11;
    smp_t m_z5;
    smp_t m_o12;
    smp_t m_o10;
  } s2_t;

  // Stage 3: the eight x terms.
  typedef struct packed {
    logic raw;
    smp_t x0;
    smp_t x1;
    smp_t x2;
    smp_t x3;
    smp_t x4;
    smp_t x5;
    smp_t x6;
    smp_t x7;
  } s3_t;

endpackage

// ===== sv/idct8_aan_fixed_clamp.sv =====
// ============================================================================
// idct8_aan_fixed_clamp
// Eight-point AAN inverse DCT of one row, raw or clamped to pixels.
// ============================================================================
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o    in_req_i  (8 coefs, raw_mode)
//   out      output     out_valid_o/out_stall_i  out_req_o (8 samples)
//
// A request enters every cycle while in_stall_o is low; its result passes through
// the four register stages (butterflies, multiplies, combine, output
// butterflies with clamp) before it is offered on out_valid_o.
// Reset clears only the stage valid bits.
// A stage loads when it is empty or the stage after it moves, so bubbles
// are squeezed out and an output stall holds the last stage and each full stage behind it.
module idct8_aan_fixed_clamp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  idct8_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output idct8_pkg::out_req_t out_req_o
);

  logic                v1, v2, v3, v4;
  logic                rdy1, rdy2, rdy3, rdy4;
  idct8_pkg::s1_t      s1;
  idct8_pkg::s2_t      s2;
  idct8_pkg::s3_t      s3;
  idct8_pkg::stg_ctl_t ctl1, ctl2, ctl3, ctl4;

  // Ready chain from the output back to the input.
  assign rdy4 = !v4 || !out_stall_i;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign ctl1 = '{vld: in_valid_i, adv: rdy1};
  assign ctl2 = '{vld: v1, adv: rdy2};
  assign ctl3 = '{vld: v2, adv: rdy3};
  assign ctl4 = '{vld: v3, adv: rdy4};

  idct8_bfly u_bfly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl1),
    .req_i  (in_req_i),
    .vld_o  (v1),
    .data_o (s1)
  );

  idct8_mult u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl2),
    .data_i (s1),
    .vld_o  (v2),
    .data_o (s2)
  );

  idct8_comb u_comb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl3),
    .data_i (s2),
    .vld_o  (v3),
    .data_o (s3)
  );

  idct8_clamp u_clamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl4),
    .data_i (s3),
    .vld_o  (v4),
    .data_o (out_req_o)
  );

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4;

endmodule

// ===== sv/idct8_bfly.sv =====
// ============================================================================
// idct8_bfly
// Stage 1: input butterflies of the even and odd parts.
// ============================================================================
module idct8_bfly (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idct8_pkg::stg_ctl_t ctl_i,
  input  idct8_pkg::in_req_t  req_i,
  output logic                vld_o,
  output idct8_pkg::s1_t      data_o
);

  logic           vld_q;
  idct8_pkg::s1_t data_d;
  idct8_pkg::s1_t data_q;
  idct8_pkg::smp_t z11, z13;

  // Even part sums wrap to 16 bits; the difference feeding the multiplier
  // keeps its full 17 bits.
  always_comb begin
    z13 = req_i.coef_5 + req_i.coef_3;
    z11 = req_i.coef_1 + req_i.coef_7;
    data_d.raw    = req_i.raw_mode;
    data_d.e10    = req_i.coef_0 + req_i.coef_4;
    data_d.e11    = req_i.coef_0 - req_i.coef_4;
    data_d.e13    = req_i.coef_2 + req_i.coef_6;
    data_d.d26    = {req_i.coef_2[15], req_i.coef_2} - {req_i.coef_6[15], req_i.coef_6};
    data_d.z10    = req_i.coef_5 - req_i.coef_3;
    data_d.z12    = req_i.coef_1 - req_i.coef_7;
    data_d.z11m13 = {z11[15], z11} - {z13[15], z13};
    data_d.z10p12 = {data_d.z10[15], data_d.z10} + {data_d.z12[15], data_d.z12};
    data_d.x7     = z11 + z13;
  end

  // Valid bit travels with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.vld) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== sv/idct8_mult.sv =====
// ============================================================================
// idct8_mult
// Stage 2: the five constant multiplies, each scaled down by 2^8.
// ============================================================================
module idct8_mult (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idct8_pkg::stg_ctl_t ctl_i,
  input  idct8_pkg::s1_t      data_i,
  output logic                vld_o,
  output idct8_pkg::s2_t      data_o
);

  logic               vld_q;
  idct8_pkg::s2_t     data_d;
  idct8_pkg::s2_t     data_q;
  logic signed [28:0] p_e12, p_o11, p_z5, p_o12, p_o10;

  // Only the low 16 bits of each shifted product are used later, so bits
  // 23:8 of the exact product stand for the arithmetic shift.
  always_comb begin
    p_e12 = data_i.d26 * idct8_pkg::K_SQRT2;
    p_o11 = data_i.z11m13 * idct8_pkg::K_SQRT2;
    p_z5  = data_i.z10p12 * idct8_pkg::K_C184;
    p_o12 = data_i.z10 * idct8_pkg::K_C261N;
    p_o10 = data_i.z12 * idct8_pkg::K_C108;
    data_d.raw   = data_i.raw;
    data_d.e10   = data_i.e10;
    data_d.e11   = data_i.e11;
    data_d.e13   = data_i.e13;
    data_d.x7    = data_i.x7;
    data_d.m_e12 = p_e12[23:8];
    data_d.m_o11 = p_o11[23:8];
    data_d.m_z5  = p_z5[23:8];
    data_d.m_o12 = p_o12[23:8];
    data_d.m_o10 = p_o10[23:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.vld) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== sv/idct8_comb.sv =====
// ============================================================================
// idct8_comb
// Stage 3: combines the products into the eight x terms.
// ============================================================================
module idct8_comb (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idct8_pkg::stg_ctl_t ctl_i,
  input  idct8_pkg::s2_t      data_i,
  output logic                vld_o,
  output idct8_pkg::s3_t      data_o
);

  logic            vld_q;
  idct8_pkg::s3_t  data_d;
  idct8_pkg::s3_t  data_q;
  idct8_pkg::smp_t e12, o12, o10;

  // All terms here wrap modulo 2^16.
  always_comb begin
    e12 = data_i.m_e12 - data_i.e13;
    o12 = data_i.m_o12 + data_i.m_z5;
    o10 = data_i.m_o10 - data_i.m_z5;
    data_d.raw = data_i.raw;
    data_d.x0  = data_i.e10 + data_i.e13;
    data_d.x3  = data_i.e10 - data_i.e13;
    data_d.x1  = data_i.e11 + e12;
    data_d.x2  = data_i.e11 - e12;
    data_d.x7  = data_i.x7;
    data_d.x6  = o12 - data_i.x7;
    data_d.x5  = data_i.m_o11 - data_d.x6;
    data_d.x4  = o10 + data_d.x5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.vld) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== sv/idct8_clamp.sv =====
// ============================================================================
// idct8_clamp
// Stage 4: output butterflies and the optional pixel clamp.
// ============================================================================
module idct8_clamp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  idct8_pkg::stg_ctl_t ctl_i,
  input  idct8_pkg::s3_t      data_i,
  output logic                vld_o,
  output idct8_pkg::out_req_t data_o
);

  logic                vld_q;
  idct8_pkg::out_req_t data_d;
  idct8_pkg::out_req_t data_q;
  idct8_pkg::smp_t     r0, r1, r2, r3, r4, r5, r6, r7;

  // Level-shifted pixel of one raw sample, or the sample itself in raw mode.
  function automatic idct8_pkg::smp_t fmt(input idct8_pkg::smp_t v, input logic raw);
    idct8_pkg::smp_t res;
    if (raw) begin
      res = v;
    end else if (v < idct8_pkg::PIX_LOW) begin
      res = idct8_pkg::PIX_MIN;
    end else if (v > idct8_pkg::PIX_HIGH) begin
      res = idct8_pkg::PIX_MAX;
    end else begin
      res = (v >>> 5) + idct8_pkg::PIX_SHIFT;
    end
    return res;
  endfunction

  always_comb begin
    r0 = data_i.x0 + data_i.x7;
    r1 = data_i.x1 + data_i.x6;
    r2 = data_i.x2 + data_i.x5;
    r3 = data_i.x3 - data_i.x4;
    r4 = data_i.x3 + data_i.x4;
    r5 = data_i.x2 - data_i.x5;
    r6 = data_i.x1 - data_i.x6;
    r7 = data_i.x0 - data_i.x7;
    data_d.out_0 = fmt(r0, data_i.raw);
    data_d.out_1 = fmt(r1, data_i.raw);
    data_d.out_2 = fmt(r2, data_i.raw);
    data_d.out_3 = fmt(r3, data_i.raw);
    data_d.out_4 = fmt(r4, data_i.raw);
    data_d.out_5 = fmt(r5, data_i.raw);
    data_d.out_6 = fmt(r6, data_i.raw);
    data_d.out_7 = fmt(r7, data_i.raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv && ctl_i.vld) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== sv/idct8_checker.sv =====
// ============================================================================
// idct8_checker
// Port-level checks of the row IDCT pipeline, bound to the top level.
// ============================================================================
module idct8_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input idct8_pkg::in_req_t  in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input idct8_pkg::out_req_t out_req_o
);

  // The pipeline only backs up to the input when the output is stalled.
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without an output stall");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // With a free output, an accepted request comes out as a valid result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result missing four cycles after request");

  // A request in pixel mode yields samples in 0..255.
  a_pixel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_req_i.raw_mode)
      ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_req_o.out_0[15:8] == 8'd0 && out_req_o.out_1[15:8] == 8'd0 &&
          out_req_o.out_2[15:8] == 8'd0 && out_req_o.out_3[15:8] == 8'd0 &&
          out_req_o.out_4[15:8] == 8'd0 && out_req_o.out_5[15:8] == 8'd0 &&
          out_req_o.out_6[15:8] == 8'd0 && out_req_o.out_7[15:8] == 8'd0)
    else $error("pixel sample out of range");

endmodule

bind idct8_aan_fixed_clamp idct8_checker u_idct8_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
